>>> design/lbv_pkg.sv
// Shared types, codes and the CRC-16/ARC byte update for the image block validator.
package lbv_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned OUT_W    = 16;  // status + block_count, padded to whole bytes
  localparam int unsigned CFG_IDX_W = 1;

  // Parser phase codes
  localparam logic [PHASE_W-1:0] PH_MARK = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HEAD = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

  // Verdict codes
  localparam logic [STATUS_W-1:0] ST_VALID     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HDR_BAD   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VER_BAD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DATA_BAD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE_BAD = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_APP_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APP_END   = 1'd1;

  // Header layout
  localparam logic [BYTE_W-1:0]  HDR_MARKER   = 8'h48;
  localparam logic [BYTE_W-1:0]  HDR_VERSION  = 8'h01;
  localparam logic [IDX_W-1:0]   IDX_VERSION  = 4'd1;
  localparam logic [IDX_W-1:0]   IDX_DEST_LO  = 4'd2;
  localparam logic [IDX_W-1:0]   IDX_LEN_LO   = 4'd6;
  localparam logic [IDX_W-1:0]   IDX_DCRC_LO  = 4'd12;
  localparam logic [IDX_W-1:0]   IDX_DCRC_HI  = 4'd13;
  localparam logic [IDX_W-1:0]   IDX_HCRC_LO  = 4'd14;
  localparam logic [IDX_W-1:0]   IDX_HCRC_HI  = 4'd15;
  localparam logic [CRC_W-1:0]   CRC_POLY     = 16'hA001;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } lbv_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] app_start;
    logic [ADDR_W-1:0] app_end;
  } lbv_window_t;

  function automatic logic [CRC_W-1:0] crc_arc(input logic [CRC_W-1:0] crc_in,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

>>> design/lbv_parse.sv
// Header/data parser: one byte per beat, header and data CRC checks, range check, verdict.
module lbv_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [lbv_pkg::BYTE_W-1:0] data_byte,
  input  logic                       first_byte,
  input  logic                       final_byte,
  input  lbv_pkg::lbv_window_t       window,
  output lbv_pkg::lbv_result_t       result
);
  import lbv_pkg::*;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]   dest_r, dest_nxt;
  logic [ADDR_W-1:0]   len_r, len_nxt;
  logic [CRC_W-1:0]    dcrc_r, dcrc_nxt;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [ADDR_W-1:0]   remain_r, remain_nxt;
  logic [COUNT_W-1:0]  blocks_r, blocks_nxt;
  logic                done_r, done_nxt;
  logic [BYTE_W-1:0]   ver_r, ver_nxt;
  logic [BYTE_W-1:0]   hcrc_lo_r, hcrc_lo_nxt;

  logic [PHASE_W-1:0]  ph_cur;
  logic                done_cur;
  logic [COUNT_W-1:0]  blocks_cur;
  logic [CRC_W-1:0]    crc_upd;
  logic [CRC_W-1:0]    fin_crc;
  logic [ADDR_W:0]     range_end;
  logic                range_bad;
  logic [1:0]          byte_sel;
  logic                hit;
  logic [STATUS_W-1:0] status;

  assign ph_cur     = first_byte ? PH_MARK : phase_r;
  assign done_cur   = first_byte ? 1'b0 : done_r;
  assign blocks_cur = first_byte ? '0 : blocks_r;
  assign crc_upd    = crc_arc(crc_r, data_byte);

  // Byte lane inside destination or length; both fields start on a 4-byte step from index 2
  assign byte_sel = idx_r[1:0] - 2'd2;

  // Range sum is one bit wider so it never wraps
  assign range_end = {1'b0, dest_r} + {1'b0, len_r};
  assign range_bad = (dest_r < window.app_start) || (range_end > {1'b0, window.app_end});

  always_comb begin
    phase_nxt   = ph_cur;
    idx_nxt     = idx_r;
    dest_nxt    = dest_r;
    len_nxt     = len_r;
    dcrc_nxt    = dcrc_r;
    crc_nxt     = crc_r;
    remain_nxt  = remain_r;
    blocks_nxt  = blocks_cur;
    done_nxt    = done_cur;
    ver_nxt     = ver_r;
    hcrc_lo_nxt = hcrc_lo_r;
    hit         = 1'b0;
    status      = ST_VALID;
    fin_crc     = crc_upd;

    if (!done_cur) begin
      unique case (ph_cur)
        PH_HEAD: begin
          if (idx_r < IDX_HCRC_LO) crc_nxt = crc_upd;
          if (idx_r == IDX_VERSION) ver_nxt = data_byte;
          if (idx_r >= IDX_DEST_LO && idx_r < IDX_LEN_LO)
            dest_nxt[BYTE_W*byte_sel +: BYTE_W] = data_byte;
          if (idx_r >= IDX_LEN_LO && idx_r < IDX_LEN_LO + 4'd4)
            len_nxt[BYTE_W*byte_sel +: BYTE_W] = data_byte;
          if (idx_r == IDX_DCRC_LO) dcrc_nxt[BYTE_W-1:0] = data_byte;
          if (idx_r == IDX_DCRC_HI) dcrc_nxt[CRC_W-1:BYTE_W] = data_byte;
          if (idx_r == IDX_HCRC_LO) hcrc_lo_nxt = data_byte;

          if (idx_r == IDX_HCRC_HI) begin
            idx_nxt = '0;
            if ({data_byte, hcrc_lo_r} != crc_r) begin
              hit    = 1'b1;
              status = ST_HDR_BAD;
            end else if (ver_r != HDR_VERSION) begin
              hit    = 1'b1;
              status = ST_VER_BAD;
            end else begin
              remain_nxt = len_r;
              crc_nxt    = '0;
              if (len_r == '0) begin
                // Empty data: data CRC of nothing is zero
                fin_crc = '0;
                if (fin_crc != dcrc_r) begin
                  hit    = 1'b1;
                  status = ST_DATA_BAD;
                end else if (range_bad) begin
                  hit    = 1'b1;
                  status = ST_RANGE_BAD;
                end else begin
                  if (blocks_cur != COUNT_MAX) blocks_nxt = blocks_cur + 1'b1;
                  phase_nxt = PH_MARK;
                end
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        PH_DATA: begin
          crc_nxt    = crc_upd;
          remain_nxt = remain_r - 1'b1;
          if (remain_r == {{(ADDR_W-1){1'b0}}, 1'b1}) begin
            if (fin_crc != dcrc_r) begin
              hit    = 1'b1;
              status = ST_DATA_BAD;
            end else if (range_bad) begin
              hit    = 1'b1;
              status = ST_RANGE_BAD;
            end else begin
              if (blocks_cur != COUNT_MAX) blocks_nxt = blocks_cur + 1'b1;
              phase_nxt = PH_MARK;
            end
          end
        end
        default: begin
          // Block boundary: a marker opens a header, anything else ends the image
          if (data_byte == HDR_MARKER) begin
            crc_nxt   = crc_arc('0, HDR_MARKER);
            idx_nxt   = IDX_VERSION;
            phase_nxt = PH_HEAD;
          end else begin
            hit    = 1'b1;
            status = ST_VALID;
          end
        end
      endcase

      if (!hit && final_byte) begin
        hit    = 1'b1;
        status = (phase_nxt == PH_MARK) ? ST_VALID : ST_TRUNC;
      end
      if (hit) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MARK;
      idx_r    <= '0;
      blocks_r <= '0;
      done_r   <= 1'b0;
      crc_r    <= '0;
      remain_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      blocks_r <= blocks_nxt;
      done_r   <= done_nxt;
      crc_r    <= crc_nxt;
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dest_r    <= dest_nxt;
      len_r     <= len_nxt;
      dcrc_r    <= dcrc_nxt;
      ver_r     <= ver_nxt;
      hcrc_lo_r <= hcrc_lo_nxt;
    end
  end

  assign result.hit    = step && hit;
  assign result.status = status;
  assign result.count  = blocks_nxt;

endmodule

>>> design/load_image_block_validator_core.sv
// Top level of the image block validator: config registers, parser and result register.
//
// Usage:
//   in_*  : one image byte per beat. in_tdata = data_byte, in_tuser = first_byte
//           (restarts the parser), in_tlast = final_byte (last byte of the region).
//   out_* : one verdict beat per image, out_tdata = {block_count, status}.
//   cfg_* : writes app_start (index 0) or app_end (index 1); always ready.
//           Write only between images or while no verdict is pending.
// Output: the verdict is registered and appears on out_* in the cycle after the byte that decides it.
// Throughput: one byte per cycle while in_tready is high; the byte is parsed, the
//   running header or data CRC advanced and the range checked in the cycle it is
//   accepted, with the verdict captured in a single output register.
// Stall: while a verdict waits and out_tready is low, in_tready drops; it stays
//   high whenever the output register is empty or being drained that cycle.
// Reset: the parser waits for the first marker with zero blocks counted, the
//   output register is empty and both window registers read zero.
module load_image_block_validator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Image byte stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lbv_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                          in_tuser,   // [0] first_byte
  input  logic                          in_tlast,   // final_byte
  // Verdict stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lbv_pkg::OUT_W-1:0]     out_tdata,  // [2:0] status, [10:3] block_count, rest 0
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbv_pkg::ADDR_W-1:0]    cfg_data
);
  import lbv_pkg::*;

  lbv_window_t  window_r;
  lbv_result_t  result;
  logic         step;
  logic         out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_APP_START: window_r.app_start <= cfg_data;
        REG_APP_END:   window_r.app_end   <= cfg_data;
        default:       window_r           <= window_r;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  lbv_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_tdata),
    .first_byte (in_tuser),
    .final_byte (in_tlast),
    .window     (window_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= result.hit;
    end
  end

  // Capture a verdict only into a free or draining register
  always_ff @(posedge clk) begin
    if (in_tready && result.hit) begin
      out_data_r <= {{(OUT_W-STATUS_W-COUNT_W){1'b0}}, result.count, result.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while a verdict is stalled");

  a_verdict_from_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |-> $past(in_tvalid && in_tready))
    else $error("verdict appeared without an accepted byte");

  a_status_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STATUS_W-1:0] <= ST_TRUNC))
    else $error("status code out of range");

endmodule
